@@ rtl/qcws_pkg.sv @@
// Package: lexer modes, byte codes and result/bundle types of the command word splitter.
`default_nettype none
package qcws_pkg;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_WORD  = 3'd1;
  localparam logic [2:0] M_WESC  = 3'd2;
  localparam logic [2:0] M_SQ    = 3'd3;
  localparam logic [2:0] M_SQESC = 3'd4;
  localparam logic [2:0] M_DQ    = 3'd5;
  localparam logic [2:0] M_DQESC = 3'd6;
  localparam logic [2:0] M_SKIP  = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] MAX_WORDS_RESET = 8'd15;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic [7:0] idx;
    logic       cend;
  } result_t;

  // up to three results caused by one input byte; count is 1..3
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic result_t mk_res(input logic [7:0] data, input logic term,
                                     input logic [7:0] idx, input logic cend);
    result_t r;
    r.data = data;
    r.term = term;
    r.idx  = idx;
    r.cend = cend;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/qcws_ifs.sv @@
// Interfaces: command byte channel and result channel.
`default_nettype none
interface qcws_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;
  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface qcws_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;
  logic [7:0] word_index;
  logic       cmd_end;
  logic       last;
  modport source (output valid, output out_byte, output is_terminator, output word_index,
                  output cmd_end, output last, input ready);
  modport sink (input valid, input out_byte, input is_terminator, input word_index,
                input cmd_end, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/quoted_command_word_splitter_top.sv @@
// Top level of the quoted command word splitter.
//
//  channel  | dir | fields
//  ---------+-----+------------------------------------------------------------
//  cmd      | in  | in_byte[7:0], end_of_buffer
//  res      | out | out_byte[7:0], is_terminator, word_index[7:0], cmd_end, last
//  cfg      | in  | cfg_we, cfg_wdata[7:0] (max_words)
//
// One byte is taken per cycle while the queue has room; its results enter the
// queue in the same cycle. The result port gives one result per cycle while
// res.ready is high, so a byte with k results needs k transfers on the output;
// the queue absorbs the bursts. Results reach the port through the queue. rst
// is synchronous and clears lexer state, queue pointers and sets max_words to 15.
`default_nettype none
module quoted_command_word_splitter_top
  import qcws_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  qcws_cmd_if.sink        cmd,
  qcws_res_if.source      res,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic    push, pop, full, empty;
  bundle_t push_data, head;

  qcws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  qcws_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  qcws_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

endmodule
`default_nettype wire

@@ rtl/qcws_front.sv @@
// Front end: lexer state, max_words register, turns each byte into a result bundle.
`default_nettype none
module qcws_front
  import qcws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  qcws_cmd_if.sink        cmd,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       full,
  output logic            push,
  output bundle_t         push_data
);

  logic [2:0] mode, mode_next;
  logic [7:0] wc, wc_next;
  logic [7:0] max_words;

  result_t [2:0] res;
  logic [1:0]    n;
  logic          do_word;
  logic [7:0]    widx;
  logic [7:0]    b;

  assign b = cmd.in_byte;
  assign cmd.ready = !full;

  always_comb begin
    res       = '0;
    n         = 2'd0;
    mode_next = mode;
    wc_next   = wc;
    do_word   = 1'b0;
    widx      = 8'(wc - 8'd1);
    if (b == CH_NUL) begin
      res[0]    = mk_res(8'd0, (mode >= M_WORD) && (mode <= M_DQESC), wc, 1'b1);
      n         = 2'd1;
      mode_next = M_IDLE;
      wc_next   = 8'd0;
    end else begin
      unique case (mode)
        M_IDLE: begin
          if (!is_ws(b)) begin
            if (wc >= max_words) begin
              mode_next = M_SKIP;
            end else begin
              wc_next = 8'(wc + 8'd1);
              widx    = wc;
              do_word = 1'b1;
            end
          end
        end
        M_WORD: do_word = 1'b1;
        M_WESC: begin
          res[n] = mk_res(b, 1'b0, widx, 1'b0);
          n = 2'(n + 2'd1);
          mode_next = M_WORD;
        end
        M_SQ: begin
          if (b == CH_SQ) begin
            mode_next = M_WORD;
          end else if (b == CH_BSL) begin
            mode_next = M_SQESC;
          end else begin
            res[n] = mk_res(b, 1'b0, widx, 1'b0);
            n = 2'(n + 2'd1);
          end
        end
        M_SQESC: begin
          if (b != CH_SQ) begin
            res[n] = mk_res(CH_BSL, 1'b0, widx, 1'b0);
            n = 2'(n + 2'd1);
          end
          res[n] = mk_res(b, 1'b0, widx, 1'b0);
          n = 2'(n + 2'd1);
          mode_next = M_SQ;
        end
        M_DQ: begin
          if (b == CH_DQ) begin
            mode_next = M_WORD;
          end else if (b == CH_BSL) begin
            mode_next = M_DQESC;
          end else begin
            res[n] = mk_res(b, 1'b0, widx, 1'b0);
            n = 2'(n + 2'd1);
          end
        end
        M_DQESC: begin
          if ((b != CH_BSL) && (b != CH_DQ)) begin
            res[n] = mk_res(CH_BSL, 1'b0, widx, 1'b0);
            n = 2'(n + 2'd1);
          end
          res[n] = mk_res(b, 1'b0, widx, 1'b0);
          n = 2'(n + 2'd1);
          mode_next = M_DQ;
        end
        M_SKIP: ;
        default: ;
      endcase
      if (do_word) begin
        if (b == CH_BSL) begin
          mode_next = M_WESC;
        end else if (is_ws(b)) begin
          res[n] = mk_res(8'd0, 1'b1, widx, 1'b0);
          n = 2'(n + 2'd1);
          mode_next = M_IDLE;
        end else if (b == CH_SQ) begin
          mode_next = M_SQ;
        end else if (b == CH_DQ) begin
          mode_next = M_DQ;
        end else begin
          res[n] = mk_res(b, 1'b0, widx, 1'b0);
          n = 2'(n + 2'd1);
          mode_next = M_WORD;
        end
      end
      if (cmd.end_of_buffer) begin
        res[n] = mk_res(8'd0, (mode_next >= M_WORD) && (mode_next <= M_DQESC),
                        wc_next, 1'b1);
        n = 2'(n + 2'd1);
        mode_next = M_IDLE;
        wc_next   = 8'd0;
      end
    end
  end

  assign push            = cmd.valid && cmd.ready && (n != 2'd0);
  assign push_data.count = n;
  assign push_data.res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      wc        <= 8'd0;
      max_words <= MAX_WORDS_RESET;
    end else begin
      if (cmd.valid && cmd.ready) begin
        mode <= mode_next;
        wc   <= wc_next;
      end
      if (cfg_we) begin
        max_words <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/qcws_fifo.sv @@
// Bundle queue between front end and back end.
`default_nettype none
module qcws_fifo
  import qcws_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  bundle_t   push_data,
  input  wire logic pop,
  output bundle_t   head,
  output logic      full,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/qcws_back.sv @@
// Back end: steps through the results of the head bundle, one per transaction.
`default_nettype none
module qcws_back
  import qcws_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  bundle_t   head,
  input  wire logic empty,
  output logic      pop,
  qcws_res_if.source res
);

  logic [1:0] sel;
  result_t    cur;
  logic       is_last;

  assign cur     = head.res[sel];
  assign is_last = (sel == 2'(head.count - 2'd1));

  assign res.valid         = !empty;
  assign res.out_byte      = cur.data;
  assign res.is_terminator = cur.term;
  assign res.word_index    = cur.idx;
  assign res.cmd_end       = cur.cend;
  assign res.last          = is_last;

  assign pop = res.valid && res.ready && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 2'd0;
    end else if (res.valid && res.ready) begin
      sel <= is_last ? 2'd0 : 2'(sel + 2'd1);
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench: feeds command bytes to the word splitter and checks every result against a predictor.
module testbench;
  import qcws_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int unsigned QUIET_LIMIT = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic [7:0] idx;
    logic       cend;
    logic       last;
  } word_res_t;

  class word_split_book;
    logic [7:0]  max_words;
    logic [2:0]  mode;
    logic [7:0]  words;
    word_res_t   due[$];
    int unsigned errors;

    function new();
      max_words = MAX_WORDS_RESET;
      mode = M_IDLE;
      words = 8'd0;
      errors = 0;
    endfunction

    function bit blank(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function void push(logic [7:0] data, logic term, logic [7:0] idx, logic cend);
      due.push_back('{data, term, idx, cend, 1'b0});
    endfunction

    function void put_char(logic [7:0] b);
      push(b, 1'b0, words - 8'd1, 1'b0);
    endfunction

    function void in_word(logic [7:0] b);
      if (b == CH_BSL) begin
        mode = M_WESC;
      end else if (blank(b)) begin
        push(8'd0, 1'b1, words - 8'd1, 1'b0);
        mode = M_IDLE;
      end else if (b == CH_SQ) begin
        mode = M_SQ;
      end else if (b == CH_DQ) begin
        mode = M_DQ;
      end else begin
        put_char(b);
      end
    endfunction

    function void close_cmd();
      push(8'd0, mode != M_IDLE && mode != M_SKIP, words, 1'b1);
      mode = M_IDLE;
      words = 8'd0;
    endfunction

    // accepted command byte: append the results it causes
    function void note_input(logic [7:0] b, logic eob);
      int n0;
      n0 = due.size();
      if (b == CH_NUL) begin
        close_cmd();
      end else begin
        case (mode)
          M_IDLE: begin
            if (!blank(b)) begin
              if (words >= max_words) begin
                mode = M_SKIP;
              end else begin
                words++;
                mode = M_WORD;
                in_word(b);
              end
            end
          end
          M_WORD: in_word(b);
          M_WESC: begin
            put_char(b);
            mode = M_WORD;
          end
          M_SQ: begin
            if (b == CH_SQ) mode = M_WORD;
            else if (b == CH_BSL) mode = M_SQESC;
            else put_char(b);
          end
          M_SQESC: begin
            if (b != CH_SQ) put_char(CH_BSL);
            put_char(b);
            mode = M_SQ;
          end
          M_DQ: begin
            if (b == CH_DQ) mode = M_WORD;
            else if (b == CH_BSL) mode = M_DQESC;
            else put_char(b);
          end
          M_DQESC: begin
            if (b != CH_BSL && b != CH_DQ) put_char(CH_BSL);
            put_char(b);
            mode = M_DQ;
          end
          default: ;
        endcase
        if (eob) close_cmd();
      end
      if (due.size() > n0) due[due.size() - 1].last = 1'b1;
    endfunction

    function void match_result(word_res_t got);
      word_res_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte %h term %b idx %0d end %b last %b", $time,
                 got.data, got.term, got.idx, got.cend, got.last);
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: expected byte %h term %b idx %0d end %b last %b", $time,
                 want.data, want.term, want.idx, want.cend, want.last);
        $display("%0t:   actual byte %h term %b idx %0d end %b last %b", $time,
                 got.data, got.term, got.idx, got.cend, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  int unsigned gap_pct;
  int unsigned stall_left;
  int unsigned quiet;
  int unsigned sent;

  word_split_book book = new();

  qcws_cmd_if cmd();
  qcws_res_if res();

  quoted_command_word_splitter_top uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready)
        book.match_result('{res.out_byte, res.is_terminator, res.word_index, res.cmd_end,
                            res.last});
      if (cmd.valid && cmd.ready) book.note_input(cmd.in_byte, cmd.end_of_buffer);
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 2) begin
      stall_left <= $urandom_range(0, 2);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic idle_sender(int unsigned n);
    cmd.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic eob);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) idle_sender($urandom_range(1, 3));
    cmd.valid <= 1'b1;
    cmd.in_byte <= b;
    cmd.end_of_buffer <= eob;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (book.due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_max_words(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.max_words = v;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = 8'($urandom_range(128, 255));
      1: b = 8'($urandom_range(1, 8));
      2: b = 8'($urandom_range(14, 31));
      default: b = 8'($urandom_range(33, 126));
    endcase
    if (b == CH_SQ || b == CH_DQ || b == CH_BSL) b = 8'h5F;
    return b;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 6))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic add_quoted(ref logic [7:0] q[$], input logic [7:0] quote);
    q.push_back(quote);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 6))
        0: q.push_back(space_char());
        1: q.push_back(quote == CH_SQ ? CH_DQ : CH_SQ);
        2: begin
          q.push_back(CH_BSL);
          q.push_back(any_char());
        end
        3: begin
          q.push_back(CH_BSL);
          q.push_back(quote);
        end
        4: begin
          q.push_back(CH_BSL);
          q.push_back(CH_BSL);
        end
        default: q.push_back(plain_char());
      endcase
    end
    q.push_back(quote);
  endtask

  task automatic add_word(ref logic [7:0] q[$]);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 4))
        0: begin
          q.push_back(CH_BSL);
          q.push_back(any_char());
        end
        1: add_quoted(q, CH_SQ);
        2: add_quoted(q, CH_DQ);
        default: repeat ($urandom_range(1, 3)) q.push_back(plain_char());
      endcase
    end
  endtask

  task automatic random_command(int unsigned max_w);
    logic [7:0]  q[$];
    logic        eob_last;
    int unsigned n;
    eob_last = 1'b0;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    if ($urandom_range(0, 3) == 0) q.push_back(space_char());
    n = $urandom_range(0, max_w);
    for (int i = 0; i < n; i++) begin
      if (i != 0) repeat ($urandom_range(1, 2)) q.push_back(space_char());
      add_word(q);
    end
    // broken tails: dangling escape, open quotes, trailing blank
    case ($urandom_range(0, 9))
      0: q.push_back(CH_BSL);
      1: begin
        q.push_back(CH_SQ);
        q.push_back(plain_char());
      end
      2: begin
        q.push_back(CH_DQ);
        q.push_back(CH_BSL);
      end
      3: q.push_back(space_char());
      default: ;
    endcase
    if (q.size() != 0 && $urandom_range(0, 1) == 1) eob_last = 1'b1;
    else q.push_back(CH_NUL);
    foreach (q[i]) send_byte(q[i], eob_last && i == q.size() - 1);
  endtask

  task automatic random_phase(int unsigned quota, int unsigned max_w);
    int unsigned goal;
    goal = sent + quota;
    while (sent < goal) random_command(max_w);
  endtask

  // runs the word count past the max_words limit
  task automatic long_command(int unsigned words_n);
    repeat (words_n) begin
      send_byte(plain_char(), 1'b0);
      send_byte(CH_SPACE, 1'b0);
    end
    send_byte(CH_NUL, 1'b0);
  endtask

  task automatic directed_bytes();
    logic [7:0] q[$];
    q = {8'h80, CH_BSL, CH_SPACE, 8'hFF, CH_TAB,
         CH_SQ, CH_BSL, CH_SQ, CH_BSL, 8'h41, CH_VT, CH_SQ,
         CH_DQ, CH_BSL, CH_BSL, CH_BSL, CH_DQ, CH_BSL, 8'h01, CH_DQ};
    foreach (q[i]) send_byte(q[i], 1'b0);
    send_byte(CH_BSL, 1'b1);
    send_byte(CH_DQ, 1'b0);
    send_byte(CH_BSL, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(CH_NUL, 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.in_byte = 8'd0;
    cmd.end_of_buffer = 1'b0;
    res.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    stall_left = 0;
    quiet = 0;
    sent = 0;
    gap_pct = 30;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_bytes();
    gap_pct = 40;
    random_phase(70, 5);
    drain();
    gap_pct = 25;
    set_max_words(8'd0);
    random_phase(30, 3);
    drain();
    gap_pct = 0;
    set_max_words(8'd20);
    long_command(22);
    drain();
    set_max_words(8'd255);
    random_phase(30, 5);
    drain();
    gap_pct = 50;
    set_max_words(8'd1);
    random_phase(50, 4);
    drain();
    gap_pct = 30;
    set_max_words(8'd3);
    random_phase(50, 5);
    drain();
    gap_pct = 0;
    set_max_words(8'($urandom_range(2, 254)));
    random_phase(60, 5);
    drain();
    if (book.errors == 0 && book.due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
